// ===== rtl/srt2d_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package srt2d_pkg;

   localparam int ANGLE_BITS = 16;
   localparam int COORD_BITS = 32;
   localparam int SCALE_BITS = 16;

   // angle split: two quarter bits, QBITS position bits inside the quarter
   localparam int QBITS = ANGLE_BITS - 2;
   localparam int U_W   = QBITS + 1;
   localparam int UU_W  = 2 * U_W;

   // hill coefficients and unit, Q16
   localparam int COEF_W = 18;
   localparam int TRIG_W = 18;
   localparam int ACC_W  = QBITS + 20;
   localparam logic signed [COEF_W-1:0] COEF_B2  = -COEF_W'(93664);
   localparam logic signed [COEF_W-1:0] COEF_B3  = COEF_W'(28128);
   localparam logic signed [ACC_W-1:0]  ACC_BASE = ACC_W'(65536) <<< QBITS;

   // datapath widths
   localparam int PK_W   = COORD_BITS + SCALE_BITS;
   localparam int SC_W   = PK_W - 8;
   localparam int PROD_W = TRIG_W + SC_W;
   localparam int MIX_W  = PROD_W + 1;
   localparam int XT_W   = MIX_W - 16;
   localparam int SUM_W  = XT_W + 1;

   // stream payloads
   localparam int REQ_RAW_W  = 4 * COORD_BITS + 2 * SCALE_BITS + ANGLE_BITS;
   localparam int REQ_DATA_W = ((REQ_RAW_W + 7) / 8) * 8;
   localparam int RSP_RAW_W  = 2 * COORD_BITS;
   localparam int RSP_DATA_W = ((RSP_RAW_W + 7) / 8) * 8;

   // register stages from input transfer to output register
   localparam int STAGES = 7;

endpackage

`default_nettype wire

// ===== rtl/srt2d_sincos.sv =====
`timescale 1ns / 1ps
`default_nettype none

module srt2d_sincos
   import srt2d_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic [ANGLE_BITS-1:0]    angle,
   output logic signed [TRIG_W-1:0]      sin_q,
   output logic signed [TRIG_W-1:0]      cos_q
);

   localparam logic [U_W-1:0]  QUARTER = U_W'(1) << QBITS;
   localparam logic [UU_W-1:0] U_HALF  = UU_W'(1) << (QBITS - 1);
   localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) <<< (QBITS - 1);

   logic [1:0]       quad;
   logic [U_W-1:0]   r_ext, r_neg;

   // stage 1
   logic [U_W-1:0]   us_ff, us_in, uc_ff, uc_in;
   logic [UU_W-1:0]  uus_ff, uus_in, uuc_ff, uuc_in;
   logic [1:0]       neg1_ff, neg1_in;

   // stage 2
   logic [UU_W-1:0]  uus_rnd, uuc_rnd;
   logic [U_W-1:0]   u2s_ff, u2s_in, u2c_ff, u2c_in;
   logic [UU_W-1:0]  ms_ff, ms_in, mc_ff, mc_in;
   logic [1:0]       neg2_ff, neg2_in;

   // stage 3
   logic [UU_W-1:0]  ms_rnd, mc_rnd;
   logic [U_W-1:0]   u3s, u3c;
   logic signed [ACC_W-1:0] accs_ff, accs_in, accc_ff, accc_in;
   logic [1:0]       neg3_ff, neg3_in;

   // stage 4
   logic signed [ACC_W-1:0]  accs_rnd, accc_rnd;
   logic signed [TRIG_W-1:0] hs, hc;
   logic signed [TRIG_W-1:0] sin_ff, sin_in, cos_ff, cos_in;

   always_comb begin
      quad  = angle[ANGLE_BITS-1 -: 2];
      r_ext = {1'b0, angle[QBITS-1:0]};
      r_neg = QUARTER - r_ext;
      // distance to the quarter peak; cosine sits one quarter ahead
      us_in   = quad[0] ? r_ext : r_neg;
      uc_in   = quad[0] ? r_neg : r_ext;
      neg1_in = {quad[1] ^ quad[0], quad[1]};
      uus_in  = UU_W'(us_in) * UU_W'(us_in);
      uuc_in  = UU_W'(uc_in) * UU_W'(uc_in);

      uus_rnd = uus_ff + U_HALF;
      uuc_rnd = uuc_ff + U_HALF;
      u2s_in  = uus_rnd[QBITS +: U_W];
      u2c_in  = uuc_rnd[QBITS +: U_W];
      ms_in   = UU_W'(u2s_in) * UU_W'(us_ff);
      mc_in   = UU_W'(u2c_in) * UU_W'(uc_ff);
      neg2_in = neg1_ff;

      ms_rnd  = ms_ff + U_HALF;
      mc_rnd  = mc_ff + U_HALF;
      u3s     = ms_rnd[QBITS +: U_W];
      u3c     = mc_rnd[QBITS +: U_W];
      accs_in = ACC_BASE + ACC_W'(COEF_B2) * $signed(ACC_W'(u2s_ff))
                + ACC_W'(COEF_B3) * $signed(ACC_W'(u3s));
      accc_in = ACC_BASE + ACC_W'(COEF_B2) * $signed(ACC_W'(u2c_ff))
                + ACC_W'(COEF_B3) * $signed(ACC_W'(u3c));
      neg3_in = neg2_ff;

      accs_rnd = accs_ff + ACC_HALF;
      accc_rnd = accc_ff + ACC_HALF;
      hs       = $signed(accs_rnd[QBITS +: TRIG_W]);
      hc       = $signed(accc_rnd[QBITS +: TRIG_W]);
      sin_in   = neg3_ff[0] ? -hs : hs;
      cos_in   = neg3_ff[1] ? -hc : hc;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         us_ff   <= us_in;
         uc_ff   <= uc_in;
         uus_ff  <= uus_in;
         uuc_ff  <= uuc_in;
         neg1_ff <= neg1_in;
         u2s_ff  <= u2s_in;
         u2c_ff  <= u2c_in;
         ms_ff   <= ms_in;
         mc_ff   <= mc_in;
         neg2_ff <= neg2_in;
         accs_ff <= accs_in;
         accc_ff <= accc_in;
         neg3_ff <= neg3_in;
         sin_ff  <= sin_in;
         cos_ff  <= cos_in;
      end
   end

   assign sin_q = sin_ff;
   assign cos_q = cos_ff;

endmodule

`default_nettype wire

// ===== rtl/scale_rotate_translate_2d.sv =====
// inputs pass scale, sine/cosine, product, sum and output registers to rsp_tdata
// throughput: one point per cycle; the whole pipeline holds while rsp_tready is low
//    and the output register is full
// reset: synchronous, active high; clears all stage valid bits, payload is not reset
`timescale 1ns / 1ps
`default_nettype none

module scale_rotate_translate_2d
   import srt2d_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // center_x, center_y, pos_x, pos_y, scale_x, scale_y, angle
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // out_x, out_y
   output logic [RSP_DATA_W-1:0]       rsp_tdata
);

   localparam logic signed [PK_W-1:0]  PK_HALF  = PK_W'(128);
   localparam logic signed [MIX_W-1:0] MIX_HALF = MIX_W'(32768);
   localparam logic signed [COORD_BITS-1:0] OUT_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] OUT_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   logic en;
   logic [STAGES-1:0] valid_ff, valid_in;

   logic signed [COORD_BITS-1:0] center_x, center_y, pos_x, pos_y;
   logic signed [SCALE_BITS-1:0] scale_x, scale_y;
   logic [ANGLE_BITS-1:0]        angle;

   logic signed [COORD_BITS-1:0] cx_ff [1:6];
   logic signed [COORD_BITS-1:0] cy_ff [1:6];

   logic signed [PK_W-1:0]   pkx_ff, pkx_in, pky_ff, pky_in;
   logic signed [PK_W-1:0]   pkx_rnd, pky_rnd;
   logic signed [SC_W-1:0]   sx_ff [2:4];
   logic signed [SC_W-1:0]   sy_ff [2:4];
   logic signed [SC_W-1:0]   sx_in, sy_in;

   logic signed [TRIG_W-1:0] sin_q, cos_q;

   logic signed [PROD_W-1:0] cxp_ff, cxp_in, syp_ff, syp_in;
   logic signed [PROD_W-1:0] sxp_ff, sxp_in, cyp_ff, cyp_in;

   logic signed [MIX_W-1:0]  mx, my;
   logic signed [XT_W-1:0]   xt_ff, xt_in, yt_ff, yt_in;

   logic signed [SUM_W-1:0]      sum_x, sum_y;
   logic signed [COORD_BITS-1:0] outx_ff, outx_in, outy_ff, outy_in;

   // whole pipeline advances together unless the output register is held
   assign en         = !valid_ff[STAGES-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = valid_ff[STAGES-1];
   assign valid_in   = {valid_ff[STAGES-2:0], req_tvalid};

   always_comb begin
      center_x = $signed(req_tdata[0*COORD_BITS +: COORD_BITS]);
      center_y = $signed(req_tdata[1*COORD_BITS +: COORD_BITS]);
      pos_x    = $signed(req_tdata[2*COORD_BITS +: COORD_BITS]);
      pos_y    = $signed(req_tdata[3*COORD_BITS +: COORD_BITS]);
      scale_x  = $signed(req_tdata[4*COORD_BITS +: SCALE_BITS]);
      scale_y  = $signed(req_tdata[4*COORD_BITS + SCALE_BITS +: SCALE_BITS]);
      angle    = req_tdata[4*COORD_BITS + 2*SCALE_BITS +: ANGLE_BITS];
   end

   srt2d_sincos u_sincos (
      .clock (clock),
      .en    (en),
      .angle (angle),
      .sin_q (sin_q),
      .cos_q (cos_q)
   );

   always_comb begin
      pkx_in = PK_W'(pos_x) * PK_W'(scale_x);
      pky_in = PK_W'(pos_y) * PK_W'(scale_y);

      pkx_rnd = pkx_ff + PK_HALF;
      pky_rnd = pky_ff + PK_HALF;
      sx_in   = $signed(pkx_rnd[8 +: SC_W]);
      sy_in   = $signed(pky_rnd[8 +: SC_W]);

      cxp_in = PROD_W'(cos_q) * PROD_W'(sx_ff[4]);
      syp_in = PROD_W'(sin_q) * PROD_W'(sy_ff[4]);
      sxp_in = PROD_W'(sin_q) * PROD_W'(sx_ff[4]);
      cyp_in = PROD_W'(cos_q) * PROD_W'(sy_ff[4]);

      // exact rotation sums, rounded half up to Q16
      mx    = MIX_W'(cxp_ff) - MIX_W'(syp_ff) + MIX_HALF;
      my    = MIX_W'(sxp_ff) + MIX_W'(cyp_ff) + MIX_HALF;
      xt_in = $signed(mx[16 +: XT_W]);
      yt_in = $signed(my[16 +: XT_W]);

      sum_x = SUM_W'(xt_ff) + SUM_W'(cx_ff[6]);
      sum_y = SUM_W'(yt_ff) + SUM_W'(cy_ff[6]);
      if (sum_x > SUM_W'(OUT_MAX)) begin
         outx_in = OUT_MAX;
      end else if (sum_x < SUM_W'(OUT_MIN)) begin
         outx_in = OUT_MIN;
      end else begin
         outx_in = sum_x[COORD_BITS-1:0];
      end
      if (sum_y > SUM_W'(OUT_MAX)) begin
         outy_in = OUT_MAX;
      end else if (sum_y < SUM_W'(OUT_MIN)) begin
         outy_in = OUT_MIN;
      end else begin
         outy_in = sum_y[COORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff[1] <= center_x;
         cy_ff[1] <= center_y;
         for (int i = 2; i <= 6; i++) begin
            cx_ff[i] <= cx_ff[i-1];
            cy_ff[i] <= cy_ff[i-1];
         end
         pkx_ff   <= pkx_in;
         pky_ff   <= pky_in;
         sx_ff[2] <= sx_in;
         sy_ff[2] <= sy_in;
         for (int i = 3; i <= 4; i++) begin
            sx_ff[i] <= sx_ff[i-1];
            sy_ff[i] <= sy_ff[i-1];
         end
         cxp_ff  <= cxp_in;
         syp_ff  <= syp_in;
         sxp_ff  <= sxp_in;
         cyp_ff  <= cyp_in;
         xt_ff   <= xt_in;
         yt_ff   <= yt_in;
         outx_ff <= outx_in;
         outy_ff <= outy_in;
      end
   end

   assign rsp_tdata = RSP_DATA_W'({outy_ff, outx_ff});

endmodule

`default_nettype wire

// ===== rtl/srt2d_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module srt2d_checker
   import srt2d_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic [REQ_DATA_W-1:0]  req_tdata,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_DATA_W-1:0]  rsp_tdata
);

   logic req_xfer;
   assign req_xfer = req_tvalid && req_tready && (req_tdata == req_tdata);

   // result held steady while the sink stalls
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a free sink never stalls the input side
   assert property (@(posedge clock) disable iff (reset)
      rsp_tready || !rsp_tvalid |-> req_tready)
      else $error("input stalled without back pressure");

   // fixed latency when the sink keeps up
   assert property (@(posedge clock) disable iff (reset)
      (req_xfer && rsp_tready) ##1 rsp_tready ##1 rsp_tready ##1 rsp_tready
      ##1 rsp_tready ##1 rsp_tready ##1 rsp_tready |=> rsp_tvalid)
      else $error("result missing after pipeline latency");

endmodule

bind scale_rotate_translate_2d srt2d_checker u_srt2d_checker (.*);

`default_nettype wire

// ===== dv/tb_scale_rotate_translate_2d.sv =====
`timescale 1ns / 1ps

module tb_scale_rotate_translate_2d;
   import srt2d_pkg::*;

   localparam int     ANG_FRAC    = ANGLE_BITS - 2;
   localparam int     XY_W        = 2 * COORD_BITS;
   localparam longint HILL_ONE    = 65536;
   localparam longint HILL_C2     = -93664;
   localparam longint HILL_C3     = 28128;
   localparam longint FRAC_HALF   = longint'(1) <<< (ANG_FRAC - 1);
   localparam longint QUARTER     = longint'(1) <<< ANG_FRAC;
   localparam int     QUIET_LIMIT = 2000;
   localparam int     PRINT_LIMIT = 40;
   localparam int     TAIL_CYCLES = 4 * STAGES;
   localparam logic   TYPED       = 1'b1;
   localparam logic   PREDICTED   = 1'b0;

   // packed in reverse so that center_x, the last field, lands in the lowest bits of tdata
   typedef struct packed {
      logic        [ANGLE_BITS-1:0] angle;
      logic signed [SCALE_BITS-1:0] scale_y;
      logic signed [SCALE_BITS-1:0] scale_x;
      logic signed [COORD_BITS-1:0] pos_y;
      logic signed [COORD_BITS-1:0] pos_x;
      logic signed [COORD_BITS-1:0] center_y;
      logic signed [COORD_BITS-1:0] center_x;
   } point_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] out_y;
      logic signed [COORD_BITS-1:0] out_x;
   } xy_type;

   typedef struct packed {
      point_type pt;
      logic      typed;
      xy_type    want;
   } dir_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // center_x, center_y, pos_x, pos_y, scale_x, scale_y, angle
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // out_x, out_y
   logic [RSP_DATA_W-1:0] rsp_tdata;

   xy_type      pending_xy[$];
   dir_row_type dir_rows[$];
   int          mismatches    = 0;
   int          quiet_cycles  = 0;
   int          send_idle_pct = 0;
   int          sink_idle_pct = 0;
   int          hold_cycles   = 0;

   scale_rotate_translate_2d u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // cubic hill of the distance to the quarter peak, Q16
   function automatic longint hill_value(input longint u);
      longint u2, u3, acc;
      u2  = (u * u + FRAC_HALF) >>> ANG_FRAC;
      u3  = (u2 * u + FRAC_HALF) >>> ANG_FRAC;
      acc = (HILL_ONE <<< ANG_FRAC) + HILL_C2 * u2 + HILL_C3 * u3;
      return (acc + FRAC_HALF) >>> ANG_FRAC;
   endfunction

   function automatic longint sine_value(input logic [ANGLE_BITS-1:0] a);
      logic [1:0] quad;
      longint     r, u, h;
      quad = a[ANGLE_BITS-1 -: 2];
      r    = longint'(a[ANG_FRAC-1:0]);
      u    = quad[0] ? r : QUARTER - r;
      h    = hill_value(u);
      return quad[1] ? -h : h;
   endfunction

   function automatic logic signed [COORD_BITS-1:0] clamp_coord(input longint v);
      longint hi, lo;
      hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[COORD_BITS-1:0];
   endfunction

   function automatic xy_type predict_point(input point_type p);
      logic [ANGLE_BITS-1:0] ac;
      longint                sn, cs, sx, sy, xt, yt;
      xy_type                r;
      ac = p.angle + ANGLE_BITS'(1 << ANG_FRAC);
      sn = sine_value(p.angle);
      cs = sine_value(ac);
      // products fit in 64 bits, so the rounding shifts are exact
      sx = (longint'(p.pos_x) * longint'(p.scale_x) + 64'sd128) >>> 8;
      sy = (longint'(p.pos_y) * longint'(p.scale_y) + 64'sd128) >>> 8;
      xt = (cs * sx - sn * sy + 64'sd32768) >>> 16;
      yt = (sn * sx + cs * sy + 64'sd32768) >>> 16;
      r.out_x = clamp_coord(xt + longint'(p.center_x));
      r.out_y = clamp_coord(yt + longint'(p.center_y));
      return r;
   endfunction

   function automatic int small_signed(input int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic point_type random_point();
      point_type p;
      case ($urandom_range(0, 3))
         0: begin
            p.center_x = $urandom();
            p.center_y = $urandom();
            p.pos_x    = $urandom();
            p.pos_y    = $urandom();
            p.scale_x  = 16'($urandom());
            p.scale_y  = 16'($urandom());
            p.angle    = 16'($urandom());
         end
         3: begin
            // centers close to the rails so the final sum crosses them
            p.center_x = $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 1 << 22)
                                              : 32'h8000_0000 + $urandom_range(0, 1 << 22);
            p.center_y = $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 1 << 22)
                                              : 32'h8000_0000 + $urandom_range(0, 1 << 22);
            p.pos_x    = small_signed(1 << 22);
            p.pos_y    = small_signed(1 << 22);
            p.scale_x  = 16'(small_signed(512));
            p.scale_y  = 16'(small_signed(512));
            p.angle    = 16'($urandom());
         end
         default: begin
            p.center_x = small_signed(1 << 24);
            p.center_y = small_signed(1 << 24);
            p.pos_x    = small_signed(1 << 21);
            p.pos_y    = small_signed(1 << 21);
            p.scale_x  = 16'(small_signed(1024));
            p.scale_y  = 16'(small_signed(1024));
            // some angles sit on or within three steps of the quarter boundaries
            if ($urandom_range(0, 3) == 0) begin
               p.angle = 16'(($urandom_range(0, 3) << ANG_FRAC) + small_signed(3));
            end else begin
               p.angle = 16'($urandom());
            end
         end
      endcase
      return p;
   endfunction

   task automatic add_row(input logic [COORD_BITS-1:0] cx, cy, px, py,
                          input logic [SCALE_BITS-1:0] kx, ky,
                          input logic [ANGLE_BITS-1:0] ang,
                          input logic typed,
                          input logic [COORD_BITS-1:0] ox, oy);
      dir_row_type row;
      row.pt.center_x = cx;
      row.pt.center_y = cy;
      row.pt.pos_x    = px;
      row.pt.pos_y    = py;
      row.pt.scale_x  = kx;
      row.pt.scale_y  = ky;
      row.pt.angle    = ang;
      row.typed       = typed;
      row.want.out_x  = ox;
      row.want.out_y  = oy;
      dir_rows.push_back(row);
   endtask

   task automatic send_point(input point_type pt, input xy_type want);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(pt);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_xy.push_back(want);
   endtask

   task automatic send_random(input int count);
      point_type pt;
      repeat (count) begin
         pt = random_point();
         send_point(pt, predict_point(pt));
      end
   endtask

   // stop offering and wait for every pending result
   task automatic drain_pending();
      req_tvalid <= 1'b0;
      while (pending_xy.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what,
                                  input logic [XY_W-1:0] got, want);
      if (mismatches < PRINT_LIMIT) begin
         $display("mismatch at %0t ns: %s got %h expected %h", $realtime, what, got, want);
      end
      mismatches++;
   endtask

   initial begin : rsp_sink
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            stall_left  = hold_cycles;
            hold_cycles = 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      xy_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[RSP_RAW_W-1:0];
         if (pending_xy.size() == 0) begin
            report_mismatch("unexpected result", got, 'x);
         end else begin
            want = pending_xy.pop_front();
            if (got.out_x !== want.out_x) begin
               report_mismatch("out_x", XY_W'(got.out_x), XY_W'(want.out_x));
            end
            if (got.out_y !== want.out_y) begin
               report_mismatch("out_y", XY_W'(got.out_y), XY_W'(want.out_y));
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;

      // exact cases: zero, identity, quarter turns, both rails, mirror, no scale, rounding
      add_row(32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0000,
              TYPED, 32'h0, 32'h0);
      add_row(32'h0003_0000, 32'h0005_0000, 32'h0001_0000, 32'hfffe_0000,
              16'h0100, 16'h0100, 16'h0000, TYPED, 32'h0004_0000, 32'h0003_0000);
      add_row(32'h0, 32'h0, 32'h0001_0000, 32'h0002_0000, 16'h0100, 16'h0100, 16'h4000,
              TYPED, 32'hfffe_0000, 32'h0001_0000);
      add_row(32'h0, 32'h0, 32'h0001_0000, 32'h0002_0000, 16'h0100, 16'h0100, 16'h8000,
              TYPED, 32'hffff_0000, 32'hfffe_0000);
      add_row(32'h0, 32'h0, 32'h0001_0000, 32'h0002_0000, 16'h0100, 16'h0100, 16'hc000,
              TYPED, 32'h0002_0000, 32'hffff_0000);
      add_row(32'h7fff_ffff, 32'h7fff_ffff, 32'h0001_0000, 32'h0001_0000,
              16'h0100, 16'h0100, 16'h0000, TYPED, 32'h7fff_ffff, 32'h7fff_ffff);
      add_row(32'h8000_0000, 32'h8000_0000, 32'hffff_0000, 32'hffff_0000,
              16'h0100, 16'h0100, 16'h0000, TYPED, 32'h8000_0000, 32'h8000_0000);
      add_row(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 16'hff00, 16'h0100, 16'h0000,
              TYPED, 32'hffff_0000, 32'h0001_0000);
      add_row(32'h1234_5678, 32'h9abc_def0, 32'h7fff_ffff, 32'h8000_0000,
              16'h0000, 16'h0000, 16'h5555, TYPED, 32'h1234_5678, 32'h9abc_def0);
      add_row(32'h0, 32'h0, 32'h0000_0001, 32'hffff_ffff, 16'h0080, 16'h0080, 16'h0000,
              TYPED, 32'h0000_0001, 32'h0000_0000);
      // the rest goes through the predictor
      add_row(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 16'h0100, 16'h0100, 16'h0001,
              PREDICTED, '0, '0);
      add_row(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 16'h0100, 16'h0100, 16'hffff,
              PREDICTED, '0, '0);
      add_row(32'h0, 32'h0, 32'h0064_0000, 32'h0032_0000, 16'h0100, 16'h0100, 16'h2000,
              PREDICTED, '0, '0);
      add_row(32'h0, 32'h0, 32'h0064_0000, 32'h0032_0000, 16'h0180, 16'h0040, 16'h3fff,
              PREDICTED, '0, '0);
      add_row(32'h0, 32'h0, 32'h0064_0000, 32'h0032_0000, 16'h0100, 16'h0100, 16'h4001,
              PREDICTED, '0, '0);
      add_row(32'h0, 32'h0, 32'h7fff_ffff, 32'h7fff_ffff, 16'h7fff, 16'h7fff, 16'h1234,
              PREDICTED, '0, '0);
      add_row(32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h8000, 16'h9abc,
              PREDICTED, '0, '0);
      add_row(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
              16'h8000, 16'h7fff, 16'hffff, PREDICTED, '0, '0);
      add_row(32'h0010_0000, 32'hfff0_0000, 32'h0003_8000, 32'hfffc_4000,
              16'h0100, 16'hfe80, 16'h6000, PREDICTED, '0, '0);
      add_row(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
              16'hffff, 16'hffff, 16'hffff, PREDICTED, '0, '0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 21;
      sink_idle_pct = 77;
      foreach (dir_rows[i]) begin
         send_point(dir_rows[i].pt,
                    dir_rows[i].typed ? dir_rows[i].want : predict_point(dir_rows[i].pt));
      end
      send_random(125);

      send_idle_pct = 77;
      sink_idle_pct = 21;
      send_random(125);

      send_idle_pct = 0;
      sink_idle_pct = 0;
      // long receiver stall with the sender still pushing, the pipeline backs up
      hold_cycles = 80;
      send_random(40);
      drain_pending();
      send_random(110);
      drain_pending();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== scale_rotate_translate_2d.f =====
rtl/srt2d_pkg.sv
rtl/srt2d_sincos.sv
rtl/scale_rotate_translate_2d.sv
rtl/srt2d_checker.sv
dv/tb_scale_rotate_translate_2d.sv
